// File: rtl/rgbpc_pkg.sv
// Shared types, constants and the channel blend function of the RGB565 pixel compositor.
package rgbpc_pkg;

	// Default palette depth.
	localparam int unsigned PALETTE_ENTRIES_DEFAULT = 256;

	// Field widths.
	localparam int unsigned PIXEL_W  = 16;
	localparam int unsigned INDEX_W  = 8;
	localparam int unsigned ALPHA_W  = 4;
	localparam int unsigned OPAC_W   = 6;
	localparam int unsigned FORMAT_W = 2;
	localparam int unsigned S_DATA_W = 64;

	// Fixed-point weights: ufixed 1.16 alpha times ufixed 1.5 opacity gives ufixed 1.21.
	localparam int unsigned A16_W     = 17;
	localparam int unsigned FGA_W     = 22;
	localparam int unsigned FIX_SHIFT = 21;
	localparam int unsigned PROD_W    = 28;
	localparam logic [FGA_W-1:0] FIX_ONE     = 22'h200000;
	localparam logic [A16_W-1:0] ALPHA_STEP  = 17'd4369;
	localparam logic [A16_W-1:0] ALPHA_FULL  = 17'h10000;
	localparam logic [ALPHA_W-1:0] ALPHA_MAX = 4'h0f;
	localparam logic [OPAC_W-1:0] OPAC_FULL  = 6'd32;

	// Image formats held in the format register.
	typedef enum logic [FORMAT_W-1:0] {
		FMT_COPY    = 2'd0,
		FMT_ALPHA4  = 2'd1,
		FMT_PALETTE = 2'd2
	} fmt_t;

	// Item kinds carried on the input tuser.
	typedef enum logic {
		OP_LOAD      = 1'b0,
		OP_COMPOSITE = 1'b1
	} opcode_t;

	// Configuration register indexes.
	typedef enum logic {
		CFG_IMAGE_FORMAT = 1'b0,
		CFG_OPACITY      = 1'b1
	} cfg_index_t;

	// One channel of the blend: (fga*f + (1-fga)*b) >> 21, truncated to six bits.
	function automatic logic [5:0] blend_ch(input logic [FGA_W-1:0] fga,
			input logic [5:0] f, input logic [5:0] b);
		logic [PROD_W-1:0] sum;
		sum = PROD_W'(fga) * PROD_W'(f) + PROD_W'(FIX_ONE - fga) * PROD_W'(b);
		return sum[FIX_SHIFT+5:FIX_SHIFT];
	endfunction

endpackage

// File: rtl/rgbpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rgbpc_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds while re is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/rgb565_image_pixel_compositor.sv
// Top level of the RGB565 pixel compositor: three-stage pipeline and palette RAM.
//
// Input words arrive on s_tvalid/s_tready with s_tdata carrying the pixel
// fields and s_tuser the item kind. A load word writes one palette entry and
// gives no output word; a composite word gives exactly one output word on
// m_tvalid/m_tready, with the RGB565 result in m_tdata and the write enable
// in m_tuser. Configuration arrives on cfg_valid/cfg_ready, which is always
// ready; it may only be written while no composite word is in flight.
// A composite word passes through the stage-one, stage-two and output registers
// before m_tvalid rises. The first stage reads the palette RAM and expands
// alpha, the second forms the 1.21 weight with one multiplier and the third
// blends the channels into the output register. Throughput is one word per
// cycle unless the receiver stalls. The whole pipeline advances together,
// so when the receiver holds m_tready low with a word waiting, s_tready
// falls and every stage holds its contents.
// Reset clears the valid bits, sets the format to copy and the opacity to
// fully opaque. The palette is not cleared: an entry reads as undefined
// until a load word has written it.
module rgb565_image_pixel_compositor #(
	parameter int unsigned PALETTE_ENTRIES = rgbpc_pkg::PALETTE_ENTRIES_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input stream.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [7:0] palette_index, [23:8] palette_color, [39:24] source_pixel,
	// [43:40] source_alpha, [59:44] background_pixel, [63:60] zero
	input  logic [rgbpc_pkg::S_DATA_W-1:0]     s_tdata,
	// [0] opcode
	input  logic                               s_tuser,
	// Output stream.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [15:0] out_pixel
	output logic [rgbpc_pkg::PIXEL_W-1:0]      m_tdata,
	// [0] write_enable
	output logic                               m_tuser,
	// Configuration write channel.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               cfg_index,
	input  logic [rgbpc_pkg::OPAC_W-1:0]       cfg_data
);

	localparam int unsigned AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam logic [rgbpc_pkg::INDEX_W:0] ENTRIES_LIM =
		(rgbpc_pkg::INDEX_W+1)'(PALETTE_ENTRIES);

	// Input field split.
	logic [rgbpc_pkg::INDEX_W-1:0] in_pidx;
	logic [rgbpc_pkg::PIXEL_W-1:0] in_pcol;
	logic [rgbpc_pkg::PIXEL_W-1:0] in_src;
	logic [rgbpc_pkg::ALPHA_W-1:0] in_alpha;
	logic [rgbpc_pkg::PIXEL_W-1:0] in_bg;

	assign in_pidx  = s_tdata[7:0];
	assign in_pcol  = s_tdata[23:8];
	assign in_src   = s_tdata[39:24];
	assign in_alpha = s_tdata[43:40];
	assign in_bg    = s_tdata[59:44];

	// Configuration registers.
	logic [rgbpc_pkg::FORMAT_W-1:0] fmt_q;
	logic [rgbpc_pkg::OPAC_W-1:0]   opacity_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q     <= rgbpc_pkg::FMT_COPY;
			opacity_q <= rgbpc_pkg::OPAC_FULL;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rgbpc_pkg::CFG_IMAGE_FORMAT: fmt_q <= cfg_data[rgbpc_pkg::FORMAT_W-1:0];
				rgbpc_pkg::CFG_OPACITY:      opacity_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline advance: everything moves when the output register is free or taken.
	logic adv;
	logic accept;
	logic valid_s1, valid_s2, valid_s3;

	assign adv      = !valid_s3 || m_tready;
	assign s_tready = adv;
	assign accept   = s_tvalid && adv;

	// Palette RAM: load words write at acceptance, composite words read.
	logic                          ram_we;
	logic [rgbpc_pkg::PIXEL_W-1:0] ram_rdata;

	assign ram_we = accept && (s_tuser == rgbpc_pkg::OP_LOAD)
		&& ({1'b0, in_pidx} < ENTRIES_LIM);

	rgbpc_ram #(
		.WIDTH (rgbpc_pkg::PIXEL_W),
		.DEPTH (PALETTE_ENTRIES),
		.AW    (AW)
	) u_palette (
		.clk   (clk),
		.we    (ram_we),
		.waddr (in_pidx[AW-1:0]),
		.wdata (in_pcol),
		.re    (adv),
		.raddr (in_src[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Valid bits travel with the data; load words leave a bubble.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_tvalid && (s_tuser == rgbpc_pkg::OP_COMPOSITE);
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage one: alpha expansion to ufixed 1.16 and opacity saturation.
	logic [rgbpc_pkg::A16_W-1:0]   a16_d;
	logic [rgbpc_pkg::OPAC_W-1:0]  op_d;
	logic [rgbpc_pkg::PIXEL_W-1:0] src_s1, bg_s1;
	logic [rgbpc_pkg::A16_W-1:0]   a16_s1;
	logic [rgbpc_pkg::OPAC_W-1:0]  op_s1;
	logic                          idx_ok_s1;

	assign a16_d = (in_alpha == rgbpc_pkg::ALPHA_MAX) ? rgbpc_pkg::ALPHA_FULL
		: rgbpc_pkg::A16_W'(in_alpha) * rgbpc_pkg::ALPHA_STEP;
	assign op_d = (opacity_q > rgbpc_pkg::OPAC_FULL) ? rgbpc_pkg::OPAC_FULL : opacity_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			src_s1    <= in_src;
			bg_s1     <= in_bg;
			a16_s1    <= a16_d;
			op_s1     <= op_d;
			idx_ok_s1 <= {1'b0, in_src[rgbpc_pkg::INDEX_W-1:0]} < ENTRIES_LIM;
		end
	end

	// Stage two: the blend weight, and the palette colour taken from the RAM.
	logic [rgbpc_pkg::FGA_W-1:0]   fga_d;
	logic [rgbpc_pkg::PIXEL_W-1:0] src_s2, bg_s2, pal_s2;
	logic [rgbpc_pkg::FGA_W-1:0]   fga_s2;
	logic                          idx_ok_s2;

	assign fga_d = rgbpc_pkg::FGA_W'(a16_s1) * rgbpc_pkg::FGA_W'(op_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			src_s2    <= src_s1;
			bg_s2     <= bg_s1;
			pal_s2    <= ram_rdata;
			fga_s2    <= fga_d;
			idx_ok_s2 <= idx_ok_s1;
		end
	end

	// Stage three: per-channel blend and format selection into the output register.
	logic [5:0]                    r_bl, g_bl, b_bl;
	logic [rgbpc_pkg::PIXEL_W-1:0] pix_d;
	logic                          we_d;
	logic [rgbpc_pkg::PIXEL_W-1:0] pix_s3;
	logic                          we_s3;

	assign r_bl = rgbpc_pkg::blend_ch(fga_s2, {1'b0, src_s2[15:11]}, {1'b0, bg_s2[15:11]});
	assign g_bl = rgbpc_pkg::blend_ch(fga_s2, src_s2[10:5], bg_s2[10:5]);
	assign b_bl = rgbpc_pkg::blend_ch(fga_s2, {1'b0, src_s2[4:0]}, {1'b0, bg_s2[4:0]});

	always_comb begin
		pix_d = bg_s2;
		we_d  = 1'b0;
		unique case (fmt_q)
			rgbpc_pkg::FMT_COPY: begin
				pix_d = src_s2;
				we_d  = 1'b1;
			end
			rgbpc_pkg::FMT_PALETTE: begin
				if (idx_ok_s2) begin
					pix_d = pal_s2;
					we_d  = 1'b1;
				end
			end
			rgbpc_pkg::FMT_ALPHA4: begin
				priority if (fga_s2 >= rgbpc_pkg::FIX_ONE) begin
					pix_d = src_s2;
					we_d  = 1'b1;
				end else if (fga_s2 != '0) begin
					pix_d = {r_bl[4:0], g_bl, b_bl[4:0]};
					we_d  = 1'b1;
				end else begin
					pix_d = bg_s2;
					we_d  = 1'b0;
				end
			end
			default: begin
				pix_d = bg_s2;
				we_d  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s3 <= pix_d;
			we_s3  <= we_d;
		end
	end

	assign m_tvalid = valid_s3;
	assign m_tdata  = pix_s3;
	assign m_tuser  = we_s3;

	// The blend weight never exceeds one.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> fga_s2 <= rgbpc_pkg::FIX_ONE)
		else $error("blend weight above one");

	// A palette load never produces an output word.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == rgbpc_pkg::OP_LOAD)) |=> !valid_s1)
		else $error("load word entered the result pipeline");

	// Copy mode always writes the frame buffer.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (fmt_q == rgbpc_pkg::FMT_COPY)) |-> m_tuser)
		else $error("copy mode result without write enable");

endmodule
